### rtl/rsis_pkg.sv
// ----------------------------------------------------------------------------
// rsis_pkg
// Shared types, opcodes, status codes and helpers of the rv32 subset core.
// ----------------------------------------------------------------------------
`default_nettype none

package rsis_pkg;

	localparam int MEM_ADDR_BITS = 16;
	localparam logic [31:0] MEM_MASK = 32'((64'd1 << MEM_ADDR_BITS) - 64'd1);

	localparam logic [6:0] OPC_ADD    = 7'h33;
	localparam logic [6:0] OPC_ADDI   = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [2:0] F3_B  = 3'd0;
	localparam logic [2:0] F3_H  = 3'd1;
	localparam logic [2:0] F3_W  = 3'd2;
	localparam logic [2:0] F3_BU = 3'd4;
	localparam logic [2:0] F3_HU = 3'd5;

	localparam logic [11:0] IMM_EBREAK = 12'h001;
	localparam logic [4:0]  REG_A0     = 5'd10;

	localparam logic [2:0] STAT_LOADED   = 3'd0;
	localparam logic [2:0] STAT_EXECUTED = 3'd1;
	localparam logic [2:0] STAT_UNKNOWN  = 3'd2;
	localparam logic [2:0] STAT_GOOD     = 3'd3;
	localparam logic [2:0] STAT_BAD      = 3'd4;
	localparam logic [2:0] STAT_HALTED   = 3'd5;

	typedef struct packed {
		logic [4:0]  ra;
		logic [4:0]  rb;
		logic [2:0]  stat;
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] val;
		logic [31:0] next_pc;
		logic [2:0]  f3;
		logic [2:0]  ld_bytes;
		logic [2:0]  st_bytes;
		logic [15:0] st_addr;
		logic [31:0] st_data;
		logic [31:0] ea;
		logic        halt;
	} rsis_exec_t;

	function automatic logic [31:0] ld_ext(input logic [2:0] f3, input logic [31:0] w);
		logic [31:0] r;
		begin
			case (f3)
				F3_B:    r = {{24{w[7]}}, w[7:0]};
				F3_BU:   r = {24'd0, w[7:0]};
				F3_H:    r = {{16{w[15]}}, w[15:0]};
				F3_HU:   r = {16'd0, w[15:0]};
				default: r = w;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

### rtl/rv32_subset_instruction_step_top.sv
// ----------------------------------------------------------------------------
// rv32_subset_instruction_step_top
// Multi-cycle rv32 subset core around a byte-wide program/data memory and a
// register file memory. One word in, one result word out.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | op, load_address, load_word
//  out     | out_valid/out_ready | status, pc_after, wb_index, wb_value,
//          |                     | store_address, store_data, store_bytes
//
// A program word writes its four bytes to memory; a step fetches four bytes,
// decodes and executes, then reads the bytes of a load or writes the bytes of a
// store; a step while halted goes straight to the result. The single byte-wide
// memory port moves one byte per cycle for fetch, load data and writes.
// Reset clears pc, halt flag and register valid bits; memory is not cleared.
// A new word is taken while a result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32_subset_instruction_step_top
	import rsis_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [15:0] load_address,
	input  wire logic [31:0] load_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [2:0]  status,
	output logic      [31:0] pc_after,
	output logic      [4:0]  wb_index,
	output logic      [31:0] wb_value,
	output logic      [15:0] store_address,
	output logic      [31:0] store_data,
	output logic      [2:0]  store_bytes
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_WRITE  = 7'b0000010,
		S_FETCH  = 7'b0000100,
		S_DECODE = 7'b0001000,
		S_EXEC   = 7'b0010000,
		S_LOAD   = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [2:0]  cnt_q;
	logic [2:0]  n_q;
	logic        pend_s1;
	logic [1:0]  pend_idx_s1;
	logic [31:0] pc_q;
	logic        halted_q;
	logic        out_valid_q;

	logic [31:0] base_q;
	logic [31:0] data_q;
	logic [31:0] buf_q;
	logic [2:0]  stat_q;
	logic        wr_q;
	logic [4:0]  rd_q;
	logic [31:0] val_q;
	logic [31:0] next_q;
	logic        is_load_q;
	logic [2:0]  f3_q;
	logic        halt_q;
	logic [15:0] st_addr_q;
	logic [31:0] st_data_q;
	logic [2:0]  st_bytes_q;

	logic [2:0]  status_q;
	logic [31:0] pc_after_q;
	logic [4:0]  wb_index_q;
	logic [31:0] wb_value_q;
	logic [15:0] store_address_q;
	logic [31:0] store_data_q;
	logic [2:0]  store_bytes_q;

	logic                     acc;
	logic                     can_out;
	logic                     fin;
	logic                     issue;
	logic                     mem_we;
	logic                     seq_done;
	logic [31:0]              addr_sum;
	logic [MEM_ADDR_BITS-1:0] mem_addr;
	logic [7:0]               mem_wdata;
	logic [7:0]               mem_rdata;
	logic [31:0]              ra_data;
	logic [31:0]              rb_data;
	logic [31:0]              fin_val;
	logic [31:0]              byte_shift;
	rsis_exec_t               ex;

	assign in_ready   = (state_q == S_IDLE);
	assign acc        = in_valid && in_ready;
	assign can_out    = !out_valid_q || out_ready;
	assign fin        = (state_q == S_FINISH) && can_out;
	assign issue      = ((state_q == S_FETCH) || (state_q == S_LOAD)) && (cnt_q != n_q);
	assign mem_we     = (state_q == S_WRITE) && (cnt_q != n_q);
	assign seq_done   = (cnt_q == n_q) && !pend_s1;
	assign addr_sum   = base_q + {29'd0, cnt_q};
	assign mem_addr   = addr_sum[MEM_ADDR_BITS-1:0];
	assign byte_shift = data_q >> {cnt_q[1:0], 3'b000};
	assign mem_wdata  = byte_shift[7:0];
	assign fin_val    = is_load_q ? ld_ext(f3_q, buf_q) : val_q;

	rsis_byte_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	rsis_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ra_addr (ex.ra),
		.rb_addr (ex.rb),
		.ra_data (ra_data),
		.rb_data (rb_data),
		.we      (fin && wr_q),
		.waddr   (rd_q),
		.wdata   (fin_val)
	);

	rsis_exec u_exec (
		.inst    (buf_q),
		.pc      (pc_q),
		.ra_data (ra_data),
		.rb_data (rb_data),
		.ex      (ex)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			pend_s1     <= 1'b0;
			pc_q        <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						cnt_q <= '0;
						n_q   <= 3'd4;
						if (!op) begin
							state_q <= S_WRITE;
						end else if (halted_q) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_WRITE: begin
					if (cnt_q != n_q) begin
						cnt_q <= cnt_q + 3'd1;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FETCH: begin
					if (issue) begin
						cnt_q <= cnt_q + 3'd1;
					end else if (seq_done) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					cnt_q <= '0;
					if (ex.ld_bytes != 3'd0) begin
						n_q     <= ex.ld_bytes;
						state_q <= S_LOAD;
					end else if (ex.st_bytes != 3'd0) begin
						n_q     <= ex.st_bytes;
						state_q <= S_WRITE;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_LOAD: begin
					if (issue) begin
						cnt_q <= cnt_q + 3'd1;
					end else if (seq_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (can_out) begin
						pc_q     <= next_q;
						halted_q <= halted_q || halt_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pend_idx_s1 <= cnt_q[1:0];
		if (pend_s1) begin
			buf_q[{pend_idx_s1, 3'b000} +: 8] <= mem_rdata;
		end
		if (acc) begin
			base_q     <= op ? pc_q : {16'd0, load_address};
			data_q     <= load_word;
			buf_q      <= '0;
			stat_q     <= !op ? STAT_LOADED : (halted_q ? STAT_HALTED : STAT_EXECUTED);
			wr_q       <= 1'b0;
			rd_q       <= '0;
			val_q      <= '0;
			next_q     <= pc_q;
			is_load_q  <= 1'b0;
			f3_q       <= '0;
			halt_q     <= 1'b0;
			st_addr_q  <= '0;
			st_data_q  <= '0;
			st_bytes_q <= '0;
		end
		if (state_q == S_EXEC) begin
			base_q     <= ex.ea;
			data_q     <= ex.st_data;
			buf_q      <= '0;
			stat_q     <= ex.stat;
			wr_q       <= ex.wr;
			rd_q       <= ex.rd;
			val_q      <= ex.val;
			next_q     <= ex.next_pc;
			is_load_q  <= (ex.ld_bytes != 3'd0);
			f3_q       <= ex.f3;
			halt_q     <= ex.halt;
			st_addr_q  <= ex.st_addr;
			st_data_q  <= ex.st_data;
			st_bytes_q <= ex.st_bytes;
		end
		if (fin) begin
			status_q        <= stat_q;
			pc_after_q      <= next_q;
			wb_index_q      <= wr_q ? rd_q : 5'd0;
			wb_value_q      <= wr_q ? fin_val : 32'd0;
			store_address_q <= st_addr_q;
			store_data_q    <= st_data_q;
			store_bytes_q   <= st_bytes_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign pc_after      = pc_after_q;
	assign wb_index      = wb_index_q;
	assign wb_value      = wb_value_q;
	assign store_address = store_address_q;
	assign store_data    = store_data_q;
	assign store_bytes   = store_bytes_q;

endmodule

`default_nettype wire

### rtl/rsis_byte_mem.sv
// ----------------------------------------------------------------------------
// rsis_byte_mem
// Single-port byte memory, one read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsis_byte_mem
	import rsis_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [MEM_ADDR_BITS-1:0] addr,
	input  wire logic [7:0]               wdata,
	output logic      [7:0]               rdata
);

	logic [7:0] mem_q [2**MEM_ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

### rtl/rsis_regfile.sv
// ----------------------------------------------------------------------------
// rsis_regfile
// 32 x 32 register file, two registered read ports, one write port.
// Entries not yet written and x0 read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rsis_regfile
	import rsis_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [4:0]  ra_addr,
	input  wire logic [4:0]  rb_addr,
	output logic      [31:0] ra_data,
	output logic      [31:0] rb_data,
	input  wire logic        we,
	input  wire logic [4:0]  waddr,
	input  wire logic [31:0] wdata
);

	logic [31:0] rf_q [32];
	logic [31:0] vld_q;
	logic [31:0] ra_raw_q;
	logic [31:0] rb_raw_q;
	logic        ra_ok_q;
	logic        rb_ok_q;

	always_ff @(posedge clk) begin
		if (we) begin
			rf_q[waddr] <= wdata;
		end
		ra_raw_q <= rf_q[ra_addr];
		rb_raw_q <= rf_q[rb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			ra_ok_q <= 1'b0;
			rb_ok_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			ra_ok_q <= vld_q[ra_addr] && (ra_addr != 5'd0);
			rb_ok_q <= vld_q[rb_addr] && (rb_addr != 5'd0);
		end
	end

	assign ra_data = ra_ok_q ? ra_raw_q : 32'd0;
	assign rb_data = rb_ok_q ? rb_raw_q : 32'd0;

endmodule

`default_nettype wire

### rtl/rsis_exec.sv
// ----------------------------------------------------------------------------
// rsis_exec
// Instruction decode and execute: register addresses, alu result, next pc,
// effective address and memory access size.
// ----------------------------------------------------------------------------
`default_nettype none

module rsis_exec
	import rsis_pkg::*;
(
	input  wire logic [31:0] inst,
	input  wire logic [31:0] pc,
	input  wire logic [31:0] ra_data,
	input  wire logic [31:0] rb_data,
	output rsis_exec_t       ex
);

	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [31:0] immi;
	logic [31:0] imms;
	logic [31:0] st_ea;
	logic        wr;

	assign opc   = inst[6:0];
	assign rd    = inst[11:7];
	assign immi  = {{20{inst[31]}}, inst[31:20]};
	assign imms  = {{20{inst[31]}}, inst[31:25], inst[11:7]};
	assign st_ea = (ra_data + imms) & MEM_MASK;

	always_comb begin
		ex          = '0;
		wr          = 1'b0;
		ex.ra       = inst[19:15];
		ex.rb       = (opc == OPC_SYSTEM) ? REG_A0 : inst[24:20];
		ex.stat     = STAT_EXECUTED;
		ex.rd       = rd;
		ex.f3       = inst[14:12];
		ex.next_pc  = pc + 32'd4;
		ex.ea       = ra_data + immi;
		unique case (opc)
			OPC_ADD: begin
				wr     = 1'b1;
				ex.val = ra_data + rb_data;
			end
			OPC_ADDI: begin
				wr     = 1'b1;
				ex.val = ra_data + immi;
			end
			OPC_LOAD: begin
				unique case (inst[14:12]) inside
					F3_B, F3_BU: ex.ld_bytes = 3'd1;
					F3_H, F3_HU: ex.ld_bytes = 3'd2;
					F3_W:        ex.ld_bytes = 3'd4;
					default:     ex.ld_bytes = 3'd0;
				endcase
				wr = (ex.ld_bytes != 3'd0);
			end
			OPC_STORE: begin
				ex.ea = ra_data + imms;
				unique case (inst[14:12])
					F3_B:    ex.st_bytes = 3'd1;
					F3_H:    ex.st_bytes = 3'd2;
					F3_W:    ex.st_bytes = 3'd4;
					default: ex.st_bytes = 3'd0;
				endcase
				if (ex.st_bytes != 3'd0) begin
					ex.st_addr = st_ea[15:0];
					ex.st_data = rb_data;
				end
			end
			OPC_LUI: begin
				wr     = 1'b1;
				ex.val = {inst[31:12], 12'd0};
			end
			OPC_JALR: begin
				wr         = 1'b1;
				ex.val     = pc + 32'd4;
				ex.next_pc = (ra_data + immi) & 32'hFFFF_FFFE;
			end
			OPC_SYSTEM: begin
				ex.next_pc = pc;
				if (inst[31:20] == IMM_EBREAK) begin
					ex.stat = (rb_data == 32'd0) ? STAT_GOOD : STAT_BAD;
					ex.halt = 1'b1;
				end
			end
			default: begin
				ex.stat = STAT_UNKNOWN;
			end
		endcase
		ex.wr = wr && (rd != 5'd0);
	end

endmodule

`default_nettype wire

### rtl/rsis_checker.sv
// ----------------------------------------------------------------------------
// rsis_checker
// Port-level checks of the rv32 subset core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsis_checker
	import rsis_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [31:0] pc_after,
	input wire logic [4:0]  wb_index,
	input wire logic [31:0] wb_value,
	input wire logic [15:0] store_address,
	input wire logic [31:0] store_data,
	input wire logic [2:0]  store_bytes
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pc_after)
			&& $stable(wb_value))
		else $error("result word changed while stalled");

	// program word, halted step and traps touch no register and store nothing
	a_no_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_LOADED || status == STAT_HALTED
			|| status == STAT_GOOD || status == STAT_BAD || status == STAT_UNKNOWN)
		|-> wb_index == 5'd0 && store_bytes == 3'd0 && store_data == 32'd0
			&& store_address == 16'd0)
		else $error("side effect reported without execution");

	// a store is an executed step, writes no register and has a size of 1, 2 or 4 bytes
	a_store: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_bytes != 3'd0 |-> status == STAT_EXECUTED && wb_index == 5'd0
			&& (store_bytes == 3'd1 || store_bytes == 3'd2 || store_bytes == 3'd4))
		else $error("bad store report");

	// no register write means zero write value
	a_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wb_index == 5'd0 |-> wb_value == 32'd0)
		else $error("write value without destination");

endmodule

bind rv32_subset_instruction_step_top rsis_checker u_rsis_checker (.*);

`default_nettype wire
